// ===== design/tcmp_pkg.sv =====
package tcmp_pkg;

    // default table depth (entries of 16-bit samples)
    localparam int TCMP_TABLE_DEPTH = 1024;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // register indexes
    localparam logic [1:0] REG_TONE_LEN    = 2'd0;
    localparam logic [1:0] REG_SILENCE_LEN = 2'd1;
    localparam logic [1:0] REG_TABLE_LEN   = 2'd2;

    // register reset values
    localparam logic [15:0] TONE_LEN_RST    = 16'd0;
    localparam logic [15:0] SILENCE_LEN_RST = 16'd4000;
    localparam logic [10:0] TABLE_LEN_RST   = 11'd1;

    localparam logic [7:0]  SILENCE_CODE = 8'hFF;
    localparam logic [15:0] MU_BIAS      = 16'h0084;
    localparam logic [14:0] MU_CLIP      = 15'd32635;

    typedef struct packed {
        logic [1:0]         operation;
        logic [9:0]         table_addr;
        logic signed [15:0] table_word;
    } t_in;

    typedef struct packed {
        logic [7:0] mulaw_sample;
        logic       in_tone;
    } t_out;

    // per-command control carried through the queue
    typedef struct packed {
        logic is_load;
        logic in_tone;
    } t_cmd_ctl;

    // sample >>> 2, then G.711 mu-law
    function automatic logic [7:0] mulaw_encode(input logic [15:0] raw);
        logic [13:0] v;
        logic [14:0] vx;
        logic [14:0] mag;
        logic [15:0] m;
        logic [7:0]  top;
        logic [2:0]  ex;
        logic [3:0]  mant;
        logic        sign;
        v    = raw[15:2];
        sign = v[13];
        vx   = {v[13], v};
        mag  = sign ? (~vx + 15'd1) : vx;
        if (mag > MU_CLIP) begin
            mag = MU_CLIP;
        end
        m   = 16'(mag) + MU_BIAS;
        top = m[14:7];
        ex  = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (top[i]) begin
                ex = 3'(i);
            end
        end
        mant = 4'(m >> (5'(ex) + 5'd3));
        return ~{sign, ex, mant};
    endfunction

endpackage

// ===== design/tcmp_queue.sv =====
module tcmp_queue
    import tcmp_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_valid,
    output logic         o_full,
    output logic [W-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/tcmp_front.sv =====
module tcmp_front
    import tcmp_pkg::*;
#(
    parameter int TABLE_DEPTH = TCMP_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           i_accept,
    input  t_in                            i_in,
    output logic                           o_push,
    output t_cmd_ctl                       o_ctl,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_addr,
    output logic [15:0]                    o_word
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [15:0]   r_tone_len;
    logic [15:0]   r_silence_len;
    logic [10:0]   r_table_len;

    logic [AW-1:0] r_idx;
    logic          r_sil;
    logic [15:0]   r_cnt;
    logic [AW-1:0] n_idx;
    logic          n_sil;
    logic [15:0]   n_cnt;

    logic [16:0]   len;
    logic [16:0]   idx_inc;
    logic [16:0]   cnt_inc;
    logic          load_ok;

    // effective table length, capped at depth
    assign len = (17'(r_table_len) > 17'(TABLE_DEPTH)) ? 17'(TABLE_DEPTH)
                                                       : 17'(r_table_len);
    assign idx_inc = 17'(r_idx) + 17'd1;
    assign cnt_inc = 17'(r_cnt) + 17'd1;
    assign load_ok = (17'(i_in.table_addr) < 17'(TABLE_DEPTH));

    always_comb begin
        n_idx  = r_idx;
        n_sil  = r_sil;
        n_cnt  = r_cnt;
        o_push = 1'b0;
        o_ctl  = '0;
        o_addr = r_idx;
        o_word = i_in.table_word;
        if (i_accept) begin
            case (i_in.operation)
                OP_LOAD: begin
                    if (load_ok) begin
                        o_push       = 1'b1;
                        o_ctl.is_load = 1'b1;
                        o_addr       = AW'(i_in.table_addr);
                    end
                end
                OP_RESTART: begin
                    n_idx = '0;
                    n_sil = 1'b0;
                    n_cnt = '0;
                end
                OP_TICK: begin
                    o_push = 1'b1;
                    if (!r_sil && (r_tone_len != '0)) begin
                        o_ctl.in_tone = 1'b1;
                        n_idx = (idx_inc >= len) ? '0 : AW'(idx_inc);
                        if (cnt_inc >= 17'(r_tone_len)) begin
                            if (r_silence_len != '0) begin
                                n_sil = 1'b1;
                            end
                            n_cnt = '0;
                        end else begin
                            n_cnt = cnt_inc[15:0];
                        end
                    end else begin
                        if (cnt_inc >= 17'(r_silence_len)) begin
                            if (r_tone_len != '0) begin
                                n_sil = 1'b0;
                            end
                            n_cnt = '0;
                        end else begin
                            n_cnt = cnt_inc[15:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_len    <= TONE_LEN_RST;
            r_silence_len <= SILENCE_LEN_RST;
            r_table_len   <= TABLE_LEN_RST;
            r_idx         <= '0;
            r_sil         <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_idx <= n_idx;
            r_sil <= n_sil;
            r_cnt <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TONE_LEN:    r_tone_len    <= i_cfg_data;
                    REG_SILENCE_LEN: r_silence_len <= i_cfg_data;
                    REG_TABLE_LEN:   r_table_len   <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== design/tcmp_back.sv =====
module tcmp_back
    import tcmp_pkg::*;
#(
    parameter int TABLE_DEPTH = TCMP_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  t_cmd_ctl                       i_ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_addr,
    input  logic [15:0]                    i_word,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    output t_out                           o_out,
    input  logic                           i_out_stall
);

    logic [15:0] r_mem [TABLE_DEPTH];
    logic [15:0] r_rd_data;
    logic        r_a_valid;
    logic        r_a_tone;
    logic        r_out_valid;
    t_out        r_out;

    logic        out_free;
    logic        a_ready;
    logic        pop_play;
    logic        pop_load;

    assign out_free = !r_out_valid || !i_out_stall;
    assign a_ready  = !r_a_valid || out_free;
    // loads retire at once, plays need room in the read stage
    assign o_q_pop  = i_q_valid && (i_ctl.is_load || a_ready);
    assign pop_play = o_q_pop && !i_ctl.is_load;
    assign pop_load = o_q_pop && i_ctl.is_load;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (pop_load) begin
            r_mem[i_addr] <= i_word;
        end
        if (pop_play) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= pop_play;
            end
            if (out_free) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_play) begin
            r_a_tone <= i_ctl.in_tone;
        end
        if (out_free && r_a_valid) begin
            r_out.mulaw_sample <= r_a_tone ? mulaw_encode(r_rd_data) : SILENCE_CODE;
            r_out.in_tone      <= r_a_tone;
        end
    end

endmodule

// ===== design/tone_cadence_mulaw_player.sv =====
// Ticks pass the queue, table read register and output register. Throughput:
// one input word per cycle unless the queue is full; loads and restarts give
// no output word. The back end takes one queued command per cycle, a play only
// with room in the read stage, through one table read port. Reset: synchronous,
// active low; clears cadence state, queue, valids; sets tone_len 0, silence_len
// 4000, table_len 1. Table stays undefined until loaded; no clearing pass.
module tone_cadence_mulaw_player
    import tcmp_pkg::*;
#(
    parameter int TABLE_DEPTH = TCMP_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    // output words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CTL_W = $bits(t_cmd_ctl);
    // queue word: control, table address, sample
    localparam int QW = CTL_W + AW + 16;

    logic          accept;
    logic          push;
    t_cmd_ctl      f_ctl;
    logic [AW-1:0] f_addr;
    logic [15:0]   f_word;

    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_data;
    t_cmd_ctl      b_ctl;
    logic [AW-1:0] b_addr;
    logic [15:0]   b_word;

    // stall only on a full queue, independent of valid
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    // front: decode, cadence counters, table index
    tcmp_front #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_in       (i_in),
        .o_push     (push),
        .o_ctl      (f_ctl),
        .o_addr     (f_addr),
        .o_word     (f_word)
    );

    // short command queue decouples the two halves
    tcmp_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_addr, f_word}),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    assign b_ctl  = q_data[QW-1 -: CTL_W];
    assign b_addr = q_data[16 +: AW];
    assign b_word = q_data[15:0];

    // back: table writes and reads in order, encode, output register
    tcmp_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_ctl       (b_ctl),
        .i_addr      (b_addr),
        .i_word      (b_word),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== design/tcmp_checker.sv =====
module tcmp_checker
    import tcmp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out        o_out
);

    // a held output word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // a held output word keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("output word changed while stalled");

    // silence words always carry the silence code
    a_silence_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.in_tone |-> o_out.mulaw_sample == SILENCE_CODE)
        else $error("silence word with non-silence code");

    // right after reset nothing is offered and input is open
    a_reset_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("outputs not cleared by reset");

endmodule

bind tone_cadence_mulaw_player tcmp_checker u_tcmp_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import tcmp_pkg::*;

    // operation 3 has no meaning and must be dropped by the block
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int RANDOM_WORDS  = 700;
    localparam int STALL_LIMIT   = 5000;  // cycles with no handshake on either side
    localparam int HOLD_AT       = 600;   // receiver cycle where the long hold-off starts
    localparam int HOLD_LEN      = 300;
    localparam int DRAIN_CYCLES  = 4;     // margin after the last owed word comes out

    typedef enum bit {ROW_WORD, ROW_REG} t_row_kind;

    // one step of the directed sequence: an input word or a register write
    typedef struct {
        t_row_kind   kind;
        t_in         w;
        bit          chk;    // typed-in expectation, otherwise predicted
        t_out        want;
        logic [1:0]  idx;
        logic [15:0] data;
    } t_plan_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = '0;
    logic [15:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    t_in         i_in        = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out        o_out;

    tone_cadence_mulaw_player dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Cadence predictor: a mirror of the block's table, registers and
    // phase state, advanced once per accepted input word.
    // ------------------------------------------------------------------
    logic [15:0] wave_copy   [TCMP_TABLE_DEPTH];
    bit          wave_loaded [TCMP_TABLE_DEPTH];
    int          play_idx        = 0;
    bit          silent_phase    = 1'b0;
    int          phase_ticks     = 0;
    int          tone_samples    = int'(TONE_LEN_RST);
    int          silence_samples = int'(SILENCE_LEN_RST);
    int          wave_len        = int'(TABLE_LEN_RST);

    t_out        pending_samples[$];   // mu-law words still owed by the block
    int          errors     = 0;
    int          burst_left = 0;

    // first phases after the directed part pin the register extremes
    int fix_tone[6] = '{65535, 0, 0,     1,     65535, 3};
    int fix_sil [6] = '{0,     0, 65535, 65535, 65535, 0};
    int fix_tlen[6] = '{2047,  7, 1,     0,     1024,  1};

    // sample >>> 2, then G.711 mu-law with bias and clip
    function automatic logic [7:0] ulaw_code(input logic [15:0] raw);
        int v, mag, biased, top, ex, mant;
        bit neg;
        v = int'($signed(raw)) >>> 2;
        neg = (v < 0);
        mag = neg ? -v : v;
        if (mag > int'(MU_CLIP)) begin
            mag = int'(MU_CLIP);
        end
        biased = mag + int'(MU_BIAS);
        top = (biased >> 7) & 'hFF;
        ex = 0;
        while (top > 1) begin
            top = top >> 1;
            ex++;
        end
        mant = (biased >> (ex + 3)) & 'hF;
        return ~{neg, 3'(ex), 4'(mant)};
    endfunction

    // table length as actually played: 0 acts as a single entry, clipped to depth
    function automatic int played_len();
        if (wave_len > TCMP_TABLE_DEPTH) begin
            return TCMP_TABLE_DEPTH;
        end
        return wave_len;
    endfunction

    function automatic void cadence_step(input t_in w, output bit makes, output t_out r);
        makes = 1'b0;
        r = '0;
        case (w.operation)
            OP_LOAD: begin
                wave_copy[w.table_addr] = w.table_word;
                wave_loaded[w.table_addr] = 1'b1;
            end
            OP_RESTART: begin
                play_idx = 0;
                silent_phase = 1'b0;
                phase_ticks = 0;
            end
            OP_TICK: begin
                makes = 1'b1;
                if (!silent_phase && tone_samples != 0) begin
                    r.mulaw_sample = ulaw_code(wave_copy[play_idx]);
                    r.in_tone = 1'b1;
                    // an index left past a shortened table still plays once, then wraps
                    play_idx++;
                    if (play_idx >= played_len()) begin
                        play_idx = 0;
                    end
                    phase_ticks++;
                    if (phase_ticks >= tone_samples) begin
                        if (silence_samples != 0) begin
                            silent_phase = 1'b1;
                        end
                        phase_ticks = 0;
                    end
                end else begin
                    r.mulaw_sample = SILENCE_CODE;
                    r.in_tone = 1'b0;
                    phase_ticks++;
                    if (phase_ticks >= silence_samples) begin
                        if (tone_samples != 0) begin
                            silent_phase = 1'b0;
                        end
                        phase_ticks = 0;
                    end
                end
            end
            default: ;  // spare op: no state change, no word
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_plan_row row_tick(input logic [7:0] samp, input bit tone);
        t_plan_row r;
        r.kind = ROW_WORD;
        r.w = '{OP_TICK, 10'($urandom), 16'($urandom)};
        r.chk = 1'b1;
        r.want = '{samp, tone};
        r.idx = REG_TONE_LEN;
        r.data = '0;
        return r;
    endfunction

    function automatic t_plan_row row_load(input int addr, input logic [15:0] word);
        t_plan_row r;
        r.kind = ROW_WORD;
        r.w = '{OP_LOAD, 10'(addr), word};
        r.chk = 1'b0;
        r.want = '0;
        r.idx = REG_TONE_LEN;
        r.data = '0;
        return r;
    endfunction

    // restart or spare op, with junk in the unused fields
    function automatic t_plan_row row_ctl(input logic [1:0] op);
        t_plan_row r;
        r.kind = ROW_WORD;
        r.w = '{op, 10'($urandom), 16'($urandom)};
        r.chk = 1'b0;
        r.want = '0;
        r.idx = REG_TONE_LEN;
        r.data = '0;
        return r;
    endfunction

    function automatic t_plan_row row_reg(input logic [1:0] idx, input logic [15:0] data);
        t_plan_row r;
        r.kind = ROW_REG;
        r.w = '0;
        r.chk = 1'b0;
        r.want = '0;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    // cadence length: mostly short so phases flip often, sometimes an extreme
    function automatic int cadence_len();
        if ($urandom_range(0, 4) == 0) begin
            return ($urandom_range(0, 1) == 0) ? 0 : 65535;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic t_in next_random_word();
        t_in w;
        int pick;
        pick = $urandom_range(0, 99);
        w.table_addr = 10'($urandom);
        w.table_word = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       w.table_word = 16'h7FFF;
                1:       w.table_word = 16'h8000;
                2:       w.table_word = 16'h0000;
                default: w.table_word = 16'hFFFF;
            endcase
        end
        if (pick < 62) begin
            w.operation = OP_TICK;
        end else if (pick < 88) begin
            w.operation = OP_LOAD;
            // keep most loads inside the part of the table that gets played
            if ($urandom_range(0, 9) < 7) begin
                w.table_addr = 10'($urandom_range(0, (played_len() == 0) ? 0 : played_len() - 1));
            end
        end else if (pick < 95) begin
            w.operation = OP_RESTART;
        end else begin
            w.operation = OP_SPARE;
        end
        // a tone tick must never read an entry that was never loaded: load it instead
        if (w.operation == OP_TICK && !silent_phase && tone_samples != 0
                && !wave_loaded[play_idx]) begin
            w.operation = OP_LOAD;
            w.table_addr = 10'(play_idx);
        end
        return w;
    endfunction

    // offer one input word in burst/gap rhythm, hold it until taken, then predict
    task automatic offer(input t_in w, input bit typed, input t_out want);
        int gap;
        bit makes;
        t_out got;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (o_in_stall);
        cadence_step(w, makes, got);
        if (makes) begin
            pending_samples.push_back(typed ? want : got);
        end
    endtask

    // stop offering and let every owed word come out, plus the pipeline tail
    // (loads give no word but may still be in flight)
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write; the caller drops the enable after the last one
    task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_TONE_LEN:    tone_samples = int'(data);
            REG_SILENCE_LEN: silence_samples = int'(data);
            REG_TABLE_LEN:   wave_len = int'(data[10:0]);
            default: ;
        endcase
    endtask

    task automatic flag_error(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern and in-order checking
    // ------------------------------------------------------------------
    initial begin
        int cyc, mode, left;
        logic [7:0] pat;
        bit s;
        cyc = 0;
        left = 0;
        mode = 0;
        pat = '0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(8, 64);
                pat = 8'($urandom);
            end
            left--;
            if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN) begin
                s = 1'b1;   // long hold-off: queue fills and input backs up
            end else begin
                case (mode)
                    0:       s = 1'b0;
                    1:       s = ($urandom_range(0, 2) == 0);
                    default: s = pat[cyc % 8];
                endcase
            end
            i_out_stall <= s;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                flag_error($sformatf("output word %h with none expected", o_out));
            end else begin
                want = pending_samples.pop_front();
                if (o_out.mulaw_sample !== want.mulaw_sample) begin
                    flag_error($sformatf("mulaw_sample %h, expected %h",
                                         o_out.mulaw_sample, want.mulaw_sample));
                end
                if (o_out.in_tone !== want.in_tone) begin
                    flag_error($sformatf("in_tone %b, expected %b (mulaw %h)",
                                         o_out.in_tone, want.in_tone, want.mulaw_sample));
                end
            end
        end
    end

    // watchdog: too long with no handshake on either channel means a hang
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_plan_row plan[$];
        bit cfg_open;
        bit [2:0] mask;
        int done, phase, n, t, s, l;
        t_in w;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Out of reset the tone length is zero, so ticks are silence.
        plan.push_back(row_tick(SILENCE_CODE, 1'b0));
        plan.push_back(row_tick(SILENCE_CODE, 1'b0));
        // field extremes in the table: full scale, negative full scale, zero, -1
        plan.push_back(row_load(0, 16'h7FFF));
        plan.push_back(row_load(1, 16'h8000));
        plan.push_back(row_load(2, 16'h0000));
        plan.push_back(row_load(3, 16'hFFFF));
        plan.push_back(row_load(TCMP_TABLE_DEPTH - 1, 16'h5A3C));
        plan.push_back(row_reg(REG_TONE_LEN, 16'd2));
        plan.push_back(row_reg(REG_SILENCE_LEN, 16'd1));
        plan.push_back(row_reg(REG_TABLE_LEN, 16'd4));
        // the count of 2 left from the silence ticks already reaches the new
        // tone length, so the first tone phase ends after one word
        plan.push_back(row_tick(8'h9F, 1'b1));
        plan.push_back(row_tick(SILENCE_CODE, 1'b0));
        plan.push_back(row_tick(8'h1F, 1'b1));
        plan.push_back(row_tick(8'hFF, 1'b1));   // entry of zero encodes as 0xFF too
        plan.push_back(row_tick(SILENCE_CODE, 1'b0));
        plan.push_back(row_tick(8'h7F, 1'b1));
        plan.push_back(row_tick(8'h9F, 1'b1));   // table wrapped to entry 0
        plan.push_back(row_ctl(OP_RESTART));
        plan.push_back(row_tick(8'h9F, 1'b1));
        plan.push_back(row_ctl(OP_SPARE));       // dropped, no word, no state change
        plan.push_back(row_tick(8'h1F, 1'b1));
        plan.push_back(row_tick(SILENCE_CODE, 1'b0));

        cfg_open = 1'b0;
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_REG) begin
                if (!cfg_open) begin
                    settle();
                end
                put_reg(plan[k].idx, plan[k].data);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                end
                cfg_open = 1'b0;
                offer(plan[k].w, plan[k].chk, plan[k].want);
            end
        end

        // Random part in phases. Each phase drains first (the sender pauses until
        // nothing is owed), rewrites some registers without a restart so that
        // counters and the read index may sit past the new lengths, then streams.
        done = 0;
        phase = 0;
        while (done < RANDOM_WORDS) begin
            settle();
            if (phase < 6) begin
                mask = 3'b111;
                t = fix_tone[phase];
                s = fix_sil[phase];
                l = fix_tlen[phase];
            end else begin
                mask = 3'($urandom);
                t = cadence_len();
                s = cadence_len();
                case ($urandom_range(0, 9))
                    0:       l = 0;
                    1:       l = TCMP_TABLE_DEPTH;
                    2:       l = 2047;
                    default: l = $urandom_range(1, 40);
                endcase
            end
            if (mask[0]) begin
                put_reg(REG_TONE_LEN, 16'(t));
            end
            if (mask[1]) begin
                put_reg(REG_SILENCE_LEN, 16'(s));
            end
            if (mask[2]) begin
                // upper bits of the write data are junk; only 11 bits are kept
                put_reg(REG_TABLE_LEN, {5'($urandom), 11'(l)});
            end
            i_cfg_we <= 1'b0;

            n = $urandom_range(40, 110);
            repeat (n) begin
                w = next_random_word();
                offer(w, 1'b0, '0);
                if (w.operation != OP_SPARE) begin
                    done++;
                end
            end
            phase++;
        end

        // drain and let the tail settle; the watchdog bounds this wait
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
